/* rtl/cll_pkg.sv */
// ----------------------------------------------------------------------------
// Cursor linked list package
// Shared types and constants for the cursor linked list engine.
// ----------------------------------------------------------------------------
package cll_pkg;

	localparam int CELLS = 128;
	localparam int IW = $clog2(CELLS);
	localparam logic [IW-1:0] FREE_HEAD = '0;
	localparam logic [IW-1:0] DATA_HEAD = IW'(CELLS - 1);

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_GET    = 3'd2,
		OP_LOCATE = 3'd3,
		OP_PRED   = 3'd4,
		OP_SUCC   = 3'd5,
		OP_LENGTH = 3'd6,
		OP_CLEAR  = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [7:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               status;
		logic signed [31:0] value_out;
		logic [6:0]         slot_index;
		logic [6:0]         count;
		logic               is_empty;
	} rsp_t;

endpackage

/* rtl/cursor_linked_list_engine.sv */
// ----------------------------------------------------------------------------
// Cursor linked list engine
// A singly linked list kept in a fixed cell array, with a small sequencer.
// ----------------------------------------------------------------------------
// One request word enters on req (req_valid, req_stall) and exactly one
// response word leaves on rsp (rsp_valid, rsp_stall). Requests are insert,
// delete, get, locate, predecessor, successor, length and clear.
// The link memory has a registered read port, and each cell visited takes
// three steps (address, registered data, update).
// After reset a clearing pass writes the initial free chain into the link
// memory, one cell per cycle; requests wait meanwhile.
// A response stays on rsp while rsp_stall is high; the block takes no new
// request until its response has been delivered.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine
	import cll_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [9:0] {
		S_INIT  = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_RADDR = 10'b0000000100,
		S_RDATA = 10'b0000001000,
		S_STEP  = 10'b0000010000,
		S_FIN1  = 10'b0000100000,
		S_FIN2  = 10'b0001000000,
		S_FIN3  = 10'b0010000000,
		S_FIN4  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	logic [IW-1:0] link_mem [CELLS];
	logic [31:0]   val_mem [CELLS];

	state_t        state_q;
	logic [IW-1:0] init_q;
	logic [IW:0]   count_q;
	logic [2:0]    op_q;
	logic [7:0]    pos_q;
	logic [31:0]   val_q;
	logic [IW-1:0] raddr_q;
	logic [IW-1:0] rdata_q;
	logic [31:0]   rval_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] prev_q;
	logic [IW-1:0] aux_q;
	logic [IW-1:0] free_q;
	logic [8:0]    steps_q;
	logic          phase_q;
	logic [31:0]   aux_val_q;
	logic          we;
	logic [IW-1:0] waddr;
	logic [IW-1:0] wdata;
	logic          vwe;
	rsp_t          rsp_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign rsp = rsp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			link_mem[waddr] <= wdata;
		end
		if (vwe) begin
			val_mem[free_q] <= val_q;
		end
		rdata_q <= link_mem[raddr_q];
		rval_q <= val_mem[raddr_q];
	end

	// Walk: cur_q is the cell whose link is being read. phase selects the
	// two passes of insert, delete and clear.
	always_comb begin
		we = 1'b0;
		waddr = init_q;
		wdata = '0;
		vwe = 1'b0;
		case (state_q)
			S_INIT: begin
				we = 1'b1;
				wdata = (init_q < IW'(CELLS - 2)) ? init_q + 1'b1 : '0;
			end
			S_FIN1: begin
				case (op_q)
					OP_INSERT: begin
						we = 1'b1;
						waddr = FREE_HEAD;
						wdata = aux_q;
						vwe = 1'b1;
					end
					OP_DELETE: begin
						we = 1'b1;
						waddr = prev_q;
						wdata = aux_q;
					end
					OP_CLEAR: begin
						we = 1'b1;
						waddr = DATA_HEAD;
						wdata = '0;
					end
					default: ;
				endcase
			end
			S_FIN2: begin
				case (op_q)
					OP_INSERT: begin
						we = 1'b1;
						waddr = free_q;
						wdata = rdata_q;
					end
					OP_DELETE: begin
						we = 1'b1;
						waddr = cur_q;
						wdata = free_q;
					end
					OP_CLEAR: begin
						we = 1'b1;
						waddr = FREE_HEAD;
						wdata = aux_q;
					end
					default: ;
				endcase
			end
			S_FIN3: begin
				case (op_q)
					OP_INSERT: begin
						we = 1'b1;
						waddr = prev_q;
						wdata = free_q;
					end
					OP_DELETE: begin
						we = 1'b1;
						waddr = FREE_HEAD;
						wdata = cur_q;
					end
					OP_CLEAR: begin
						we = 1'b1;
						waddr = prev_q;
						wdata = free_q;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Walk protocol: raddr_q set in S_IDLE or S_STEP and read in S_RADDR, data valid in S_STEP.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			count_q <= '0;
			op_q <= '0;
			pos_q <= '0;
			val_q <= '0;
			raddr_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			aux_q <= '0;
			free_q <= '0;
			steps_q <= '0;
			phase_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == IW'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q <= req.req_type;
						pos_q <= req.position;
						val_q <= req.value;
						rsp_q <= '0;
						steps_q <= '0;
						phase_q <= 1'b0;
						case (op_t'(req.req_type))
							OP_INSERT: begin
								if (req.position == 8'd0 ||
										{1'b0, req.position} > 9'(count_q) + 9'd1) begin
									rsp_q.status <= 1'b1;
									state_q <= S_FIN4;
								end else begin
									raddr_q <= FREE_HEAD;
									cur_q <= FREE_HEAD;
									state_q <= S_RADDR;
								end
							end
							OP_DELETE, OP_GET: begin
								if (req.position == 8'd0 ||
										{1'b0, req.position} > 9'(count_q)) begin
									rsp_q.status <= 1'b1;
									state_q <= S_FIN4;
								end else begin
									raddr_q <= DATA_HEAD;
									cur_q <= DATA_HEAD;
									state_q <= S_RADDR;
								end
							end
							OP_LOCATE, OP_PRED, OP_SUCC: begin
								if (op_t'(req.req_type) == OP_PRED && count_q == '0) begin
									rsp_q.status <= 1'b1;
									state_q <= S_FIN4;
								end else begin
									raddr_q <= DATA_HEAD;
									cur_q <= DATA_HEAD;
									state_q <= S_RADDR;
								end
							end
							OP_CLEAR: begin
								if (count_q == '0) begin
									state_q <= S_FIN4;
								end else begin
									raddr_q <= FREE_HEAD;
									cur_q <= FREE_HEAD;
									state_q <= S_RADDR;
								end
							end
							default: state_q <= S_FIN4;
						endcase
					end
				end
				S_RADDR: state_q <= S_RDATA;
				S_RDATA: state_q <= S_STEP;
				S_STEP: begin
					// rdata_q = link of raddr_q, rval_q = value of raddr_q
					steps_q <= steps_q + 1'b1;
					state_q <= S_RADDR;
					raddr_q <= rdata_q;
					prev_q <= cur_q;
					cur_q <= rdata_q;
					case (op_q)
						OP_INSERT: begin
							if (!phase_q) begin
								if (rdata_q == '0) begin
									rsp_q.status <= 1'b1;
									state_q <= S_FIN4;
								end else begin
									free_q <= rdata_q;
									phase_q <= 1'b1;
									steps_q <= '0;
									raddr_q <= rdata_q;
									cur_q <= rdata_q;
								end
							end else if (cur_q == free_q && steps_q == '0) begin
								// link of the new cell, then walk from the head
								aux_q <= rdata_q;
								raddr_q <= DATA_HEAD;
								cur_q <= DATA_HEAD;
								steps_q <= 9'd1;
							end else if (steps_q == 9'(pos_q)) begin
								prev_q <= cur_q;
								raddr_q <= cur_q;
								state_q <= S_FIN1;
							end
						end
						OP_DELETE: begin
							if (steps_q == 9'(pos_q) - 9'd1) begin
								prev_q <= cur_q;
								cur_q <= rdata_q;
								raddr_q <= rdata_q;
								phase_q <= 1'b1;
							end else if (phase_q) begin
								aux_q <= rdata_q;
								rsp_q.value_out <= rval_q;
								cur_q <= cur_q;
								prev_q <= prev_q;
								raddr_q <= FREE_HEAD;
								phase_q <= 1'b0;
								steps_q <= 9'h1ff;
							end else if (steps_q == 9'h1ff) begin
								free_q <= rdata_q;
								cur_q <= cur_q;
								prev_q <= prev_q;
								state_q <= S_FIN1;
							end
						end
						OP_GET: begin
							if (steps_q == 9'(pos_q)) begin
								rsp_q.value_out <= rval_q;
								state_q <= S_FIN4;
							end
						end
						OP_LOCATE, OP_SUCC: begin
							if (steps_q != '0 && rval_q == val_q && !phase_q) begin
								if (op_q == OP_LOCATE) begin
									rsp_q.slot_index <= 7'(cur_q);
									state_q <= S_FIN4;
								end else if (rdata_q == '0) begin
									rsp_q.status <= 1'b1;
									state_q <= S_FIN4;
								end else begin
									phase_q <= 1'b1;
								end
							end else if (phase_q) begin
								rsp_q.value_out <= rval_q;
								state_q <= S_FIN4;
							end else if (rdata_q == '0) begin
								rsp_q.status <= 1'b1;
								state_q <= S_FIN4;
							end
						end
						OP_PRED: begin
							if (steps_q >= 9'd2 && rval_q == val_q) begin
								rsp_q.value_out <= aux_val_q;
								state_q <= S_FIN4;
							end else if (rdata_q == '0) begin
								rsp_q.status <= 1'b1;
								state_q <= S_FIN4;
							end
						end
						OP_CLEAR: begin
							if (!phase_q) begin
								aux_q <= rdata_q;
								phase_q <= 1'b1;
								raddr_q <= DATA_HEAD;
								cur_q <= DATA_HEAD;
							end else if (steps_q == 9'd1) begin
								free_q <= rdata_q;
							end else if (rdata_q == '0) begin
								prev_q <= cur_q;
								free_q <= aux_q;
								aux_q <= free_q;
								state_q <= S_FIN1;
							end
						end
						default: state_q <= S_FIN4;
					endcase
				end
				S_FIN1: state_q <= S_FIN2;
				S_FIN2: state_q <= S_FIN3;
				S_FIN3: begin
					state_q <= S_FIN4;
					case (op_q)
						OP_INSERT: count_q <= count_q + 1'b1;
						OP_DELETE: count_q <= count_q - 1'b1;
						OP_CLEAR:  count_q <= '0;
						default: ;
					endcase
				end
				S_FIN4: begin
					rsp_q.count <= 7'(count_q);
					rsp_q.is_empty <= (count_q == '0);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_STEP) begin
			aux_val_q <= rval_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (IW+1)'(CELLS - 2))
		else $error("element count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.is_empty == (rsp.count == '0))
		else $error("empty flag disagrees with count");

endmodule
